// ===== design/dhef_pkg.sv =====
package dhef_pkg;

	// Field widths
	localparam int unsigned TIME_W = 32;
	localparam int unsigned SEQ_W  = 16;
	localparam int unsigned DEB_W  = 12;
	localparam int unsigned WIN_W  = 22;   // holds 4095 * 1000

	// Debounce time scaling and reset values
	localparam logic [9:0]       US_PER_MS      = 10'd1000;
	localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 12'd50;
	localparam logic [SEQ_W-1:0] SEQ_RESET      = 16'd1;

	// Input kind carried on tuser
	localparam logic MODE_EDGE = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	// Result status carried on tuser
	typedef enum logic [2:0] {
		ST_DEBOUNCED    = 3'd0,
		ST_QUEUED       = 3'd1,
		ST_DROPPED_FULL = 3'd2,
		ST_POP_EMPTY    = 3'd3,
		ST_POP_EVENT    = 3'd4
	} status_t;

endpackage

// ===== design/debounced_hit_event_fifo_core.sv =====
// Debounced hit event queue. Each input transfer is either a receiver edge
// (tuser = 0) or a pop request (tuser = 1), and each gives exactly one result
// transfer. An edge closer than debounce_ms * 1000 us to the last accepted edge
// (32-bit wrapping distance on now_us) is ignored; an accepted edge takes the
// next 16-bit sequence number (first is 1) and is queued with its now_ms time
// in a ring of QUEUE_DEPTH slots that keeps one slot free, so it holds at most
// QUEUE_DEPTH-1 hits. When full the hit is dropped, but its sequence number is
// still used. The synchronous ring memory is read at the accepting edge; the
// item then executes once the result register is free or being taken, which
// updates the pointers, writes back and loads the result register. One item
// is in flight at a time, so a new item is not accepted until the last one has
// executed. The result register lets the next item be accepted while a finished
// result waits to be taken. debounce_ms may be written only while no item is
// in flight.
module debounced_hit_event_fifo_core #(
	parameter int unsigned QUEUE_DEPTH = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration
	input  logic                        cfg_we,
	input  logic [dhef_pkg::DEB_W-1:0]  cfg_wdata,     // debounce_ms
	// Input stream
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [63:0]                 s_axis_tdata,  // [31:0] now_us, [63:32] now_ms
	input  logic                        s_axis_tuser,  // [0] mode
	// Result stream
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [47:0]                 m_axis_tdata,  // [31:0] event_time_ms, [47:32] event_seq
	output logic [2:0]                  m_axis_tuser   // [2:0] status
);

	localparam int unsigned PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int unsigned ENTRY_W = dhef_pkg::TIME_W + dhef_pkg::SEQ_W;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	// Ring storage: {seq, time_ms}
	logic [ENTRY_W-1:0] ring_mem [QUEUE_DEPTH];

	// Control state
	logic                          busy_q;
	logic                          out_valid_q;
	logic [PTR_W-1:0]              rd_ptr_q;
	logic [PTR_W-1:0]              wr_ptr_q;
	logic [dhef_pkg::TIME_W-1:0]   last_edge_q;
	logic [dhef_pkg::SEQ_W-1:0]    next_seq_q;
	logic [dhef_pkg::WIN_W-1:0]    window_q;

	// Item held while the ring read completes
	logic                          mode_s1;
	logic [dhef_pkg::TIME_W-1:0]   now_us_s1;
	logic [dhef_pkg::TIME_W-1:0]   now_ms_s1;
	logic [ENTRY_W-1:0]            rd_data_s1;

	// Result register
	dhef_pkg::status_t             out_status_q;
	logic [dhef_pkg::TIME_W-1:0]   out_time_q;
	logic [dhef_pkg::SEQ_W-1:0]    out_seq_q;

	// Execute stage signals
	logic                          in_xfer;
	logic                          exec_fire;
	logic [dhef_pkg::TIME_W-1:0]   edge_dist;
	logic                          too_soon;
	logic [PTR_W-1:0]              wr_next;
	logic [PTR_W-1:0]              rd_next;
	logic                          ring_full;
	logic                          ring_empty;
	logic                          do_edge;
	logic                          do_push;
	logic                          do_pop;
	dhef_pkg::status_t             status_c;
	logic [dhef_pkg::TIME_W-1:0]   time_c;
	logic [dhef_pkg::SEQ_W-1:0]    seq_c;

	assign s_axis_tready = !busy_q;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign exec_fire     = busy_q && (!out_valid_q || m_axis_tready);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_seq_q, out_time_q};
	assign m_axis_tuser  = out_status_q;

	// Ring pointer arithmetic and debounce check
	assign edge_dist  = now_us_s1 - last_edge_q;
	assign too_soon   = edge_dist < {{(dhef_pkg::TIME_W - dhef_pkg::WIN_W){1'b0}}, window_q};
	assign wr_next    = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
	assign rd_next    = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
	assign ring_full  = (wr_next == rd_ptr_q);
	assign ring_empty = (rd_ptr_q == wr_ptr_q);

	// Decide the outcome of the item in flight
	always_comb begin
		do_edge  = 1'b0;
		do_push  = 1'b0;
		do_pop   = 1'b0;
		status_c = dhef_pkg::ST_DEBOUNCED;
		time_c   = '0;
		seq_c    = '0;
		if (mode_s1 == dhef_pkg::MODE_EDGE) begin
			if (!too_soon) begin
				do_edge = 1'b1;
				seq_c   = next_seq_q;
				if (ring_full) begin
					status_c = dhef_pkg::ST_DROPPED_FULL;
				end else begin
					do_push  = 1'b1;
					status_c = dhef_pkg::ST_QUEUED;
				end
			end
		end else begin
			if (ring_empty) begin
				status_c = dhef_pkg::ST_POP_EMPTY;
			end else begin
				do_pop   = 1'b1;
				status_c = dhef_pkg::ST_POP_EVENT;
				time_c   = rd_data_s1[dhef_pkg::TIME_W-1:0];
				seq_c    = rd_data_s1[ENTRY_W-1:dhef_pkg::TIME_W];
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			last_edge_q <= '0;
			next_seq_q  <= dhef_pkg::SEQ_RESET;
			window_q    <= dhef_pkg::WIN_W'(dhef_pkg::DEBOUNCE_RESET)
				* dhef_pkg::WIN_W'(dhef_pkg::US_PER_MS);
		end else begin
			if (cfg_we) begin
				window_q <= dhef_pkg::WIN_W'(cfg_wdata) * dhef_pkg::WIN_W'(dhef_pkg::US_PER_MS);
			end
			if (in_xfer) begin
				busy_q <= 1'b1;
			end else if (exec_fire) begin
				busy_q <= 1'b0;
			end
			if (exec_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (exec_fire && do_edge) begin
				last_edge_q <= now_us_s1;
				next_seq_q  <= next_seq_q + 1'b1;
			end
			if (exec_fire && do_push) begin
				wr_ptr_q <= wr_next;
			end
			if (exec_fire && do_pop) begin
				rd_ptr_q <= rd_next;
			end
		end
	end

	// Capture item and read the oldest entry
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_s1    <= s_axis_tuser;
			now_us_s1  <= s_axis_tdata[31:0];
			now_ms_s1  <= s_axis_tdata[63:32];
			rd_data_s1 <= ring_mem[rd_ptr_q];
		end
	end

	// Ring write-back
	always_ff @(posedge clk) begin
		if (exec_fire && do_push) begin
			ring_mem[wr_ptr_q] <= {next_seq_q, now_ms_s1};
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (exec_fire) begin
			out_status_q <= status_c;
			out_time_q   <= time_c;
			out_seq_q    <= seq_c;
		end
	end

	// Checks
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> busy_q)
		else $error("item accepted but execute stage not busy");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_ptr_q <= PTR_LAST) && (wr_ptr_q <= PTR_LAST))
		else $error("ring pointer out of range");

	a_pop_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_fire && status_c == dhef_pkg::ST_POP_EVENT) |=> (rd_ptr_q != $past(rd_ptr_q)))
		else $error("pop returned an event without advancing read pointer");

	a_seq_on_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_fire && (status_c == dhef_pkg::ST_QUEUED || status_c == dhef_pkg::ST_DROPPED_FULL))
		|=> (next_seq_q == $past(next_seq_q) + 1'b1))
		else $error("accepted edge did not consume a sequence number");

endmodule

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = 8;
	localparam int HOLD_CYCLES = 80;

	typedef struct {
		logic        mode;
		logic [31:0] us;
		logic [31:0] ms;
	} hit_in_t;

	typedef struct {
		dhef_pkg::status_t status;
		logic [31:0]       time_ms;
		logic [15:0]       seq;
	} hit_out_t;

	// DUT connections; the inputs are all driven to known values from time zero
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [11:0] cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;
	logic [2:0]  m_tuser;

	// Hits and pops waiting to be sent, results waiting to arrive
	hit_in_t  edge_pop_q[$];
	hit_out_t due_results[$];
	hit_in_t  cur_item;

	// Shadow of the block: ring contents, pointers, debounce tracking
	logic [31:0]                ring_ms[DEPTH];
	logic [15:0]                ring_seq[DEPTH];
	int                         m_rd       = 0;
	int                         m_wr       = 0;
	logic [31:0]                m_last_us  = '0;
	logic [15:0]                m_next_seq = dhef_pkg::SEQ_RESET;
	logic [dhef_pkg::DEB_W-1:0] m_debounce = dhef_pkg::DEBOUNCE_RESET;

	// Run bookkeeping
	int   status_seen[5] = '{0, 0, 0, 0, 0};
	int   n_checked   = 0;
	int   n_mismatch  = 0;
	int   n_settings  = 1;
	bit   idle_on     = 1'b1;
	bit   hold_go     = 1'b0;
	int   hold_left   = 0;
	int   tx_gap      = 0;
	int   rx_stall    = 0;
	logic [31:0] gen_last = '0;
	logic [31:0] gen_ms   = '0;
	logic [11:0] deb_plan[6] = '{12'd0, 12'd4000, 12'd1, 12'd4095, 12'd0, 12'd2};

	debounced_hit_event_fifo_core #(.QUEUE_DEPTH(DEPTH)) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Debounce check, sequence numbering and ring push/pop for one transfer
	function automatic hit_out_t hit_fifo_step(input hit_in_t it);
		hit_out_t    r;
		logic [31:0] window;
		logic [31:0] gap;
		int          nw;
		r.status  = dhef_pkg::ST_DEBOUNCED;
		r.time_ms = '0;
		r.seq     = '0;
		if (it.mode == dhef_pkg::MODE_EDGE) begin
			window = 32'(m_debounce) * 32'(dhef_pkg::US_PER_MS);
			gap    = it.us - m_last_us;
			if (gap >= window) begin
				nw         = (m_wr + 1) % DEPTH;
				r.seq      = m_next_seq;
				m_last_us  = it.us;
				m_next_seq = m_next_seq + 16'd1;
				if (nw == m_rd) begin
					r.status = dhef_pkg::ST_DROPPED_FULL;
				end else begin
					ring_ms[m_wr]  = it.ms;
					ring_seq[m_wr] = r.seq;
					m_wr           = nw;
					r.status       = dhef_pkg::ST_QUEUED;
				end
			end
		end else if (m_rd == m_wr) begin
			r.status = dhef_pkg::ST_POP_EMPTY;
		end else begin
			r.time_ms = ring_ms[m_rd];
			r.seq     = ring_seq[m_rd];
			m_rd      = (m_rd + 1) % DEPTH;
			r.status  = dhef_pkg::ST_POP_EVENT;
		end
		status_seen[r.status]++;
		return r;
	endfunction

	// Sender: predicts on each accepted transfer, then offers the next item
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				due_results.push_back(hit_fifo_step(cur_item));
			if (!s_tvalid || s_tready) begin
				if (tx_gap != 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (edge_pop_q.size() != 0 &&
						!(idle_on && $urandom_range(0, 5) == 0)) begin
					cur_item = edge_pop_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {cur_item.ms, cur_item.us};
					s_tuser  <= cur_item.mode;
				end else begin
					if (edge_pop_q.size() != 0)
						tx_gap = $urandom_range(0, 3);
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_go)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// Receiver: checks each result transfer, stalls in random bursts
	always @(posedge clk) begin
		hit_out_t exp_r;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				n_checked++;
				if (due_results.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("tb: unexpected result status %0d time %h seq %0d",
							m_tuser, m_tdata[31:0], m_tdata[47:32]);
				end else begin
					exp_r = due_results.pop_front();
					if (m_tuser !== exp_r.status || m_tdata[31:0] !== exp_r.time_ms ||
							m_tdata[47:32] !== exp_r.seq) begin
						n_mismatch++;
						if (n_mismatch <= 10)
							$display({"tb: mismatch exp status %0d time %h seq %0d,",
								" got status %0d time %h seq %0d"},
								exp_r.status, exp_r.time_ms, exp_r.seq,
								m_tuser, m_tdata[31:0], m_tdata[47:32]);
					end
				end
			end
			if (hold_left != 0) begin
				m_tready <= 1'b0;
			end else if (rx_stall != 0) begin
				rx_stall--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				rx_stall = $urandom_range(0, 3);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic add_item(input logic mode, input logic [31:0] us, input logic [31:0] ms);
		hit_in_t it;
		it.mode = mode;
		it.us   = us;
		it.ms   = ms;
		edge_pop_q.push_back(it);
	endtask

	// Block until nothing is queued, on the bus or outstanding
	task automatic wait_drained();
		do
			@(negedge clk);
		while (edge_pop_q.size() != 0 || s_tvalid || due_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_debounce(input logic [11:0] val);
		@(posedge clk);
		cfg_we     <= 1'b1;
		cfg_wdata  <= val;
		m_debounce = val;
		@(posedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// Bursts of edges or pops; edge times cluster around the debounce window
	task automatic load_random(input int n);
		int          left;
		int          burst;
		int          pick;
		logic        kind;
		logic [31:0] window;
		logic [31:0] delta;
		window   = 32'(m_debounce) * 32'(dhef_pkg::US_PER_MS);
		gen_last = m_last_us;
		left     = n;
		while (left > 0) begin
			kind  = ($urandom_range(0, 99) < 55) ? dhef_pkg::MODE_EDGE : dhef_pkg::MODE_POP;
			burst = $urandom_range(1, 10);
			for (int i = 0; i < burst && left > 0; i++) begin
				if (kind == dhef_pkg::MODE_POP) begin
					add_item(dhef_pkg::MODE_POP, $urandom(), $urandom());
				end else begin
					pick = $urandom_range(0, 99);
					if (window == 0 || pick < 15)
						delta = $urandom();
					else if (pick < 45)
						delta = $urandom_range(0, window - 1);
					else if (pick < 55)
						delta = window - 1;
					else if (pick < 65)
						delta = window;
					else
						delta = window + $urandom_range(0, window);
					gen_ms = ($urandom_range(0, 4) == 0) ? $urandom() :
						gen_ms + $urandom_range(0, 500);
					add_item(dhef_pkg::MODE_EDGE, gen_last + delta, gen_ms);
					if (delta >= window)
						gen_last = gen_last + delta;
				end
				left--;
			end
		end
	endtask

	initial begin
		int need;
		int k;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, reset debounce of 50 ms: early edges, window boundary,
		// wrapping distance, empty pop, ring fill and drop, drain to empty
		add_item(dhef_pkg::MODE_EDGE, 32'd0, 32'h1234_5678);
		add_item(dhef_pkg::MODE_EDGE, 32'd49999, 32'h0000_0001);
		add_item(dhef_pkg::MODE_POP, $urandom(), $urandom());
		add_item(dhef_pkg::MODE_EDGE, 32'd50000, 32'hFFFF_FFFF);
		add_item(dhef_pkg::MODE_POP, $urandom(), $urandom());
		add_item(dhef_pkg::MODE_EDGE, 32'hFFFF_FFFF, 32'h0000_0000);
		add_item(dhef_pkg::MODE_EDGE, 32'd49998, 32'hA5A5_A5A5);
		add_item(dhef_pkg::MODE_EDGE, 32'd49999, 32'h5A5A_5A5A);
		for (k = 1; k <= 7; k++)
			add_item(dhef_pkg::MODE_EDGE, 32'd49999 + 32'd50000 * k, $urandom());
		for (k = 0; k < DEPTH; k++)
			add_item(dhef_pkg::MODE_POP, $urandom(), $urandom());
		wait_drained();

		// Random phases over several debounce settings
		deb_plan[4] = 12'($urandom_range(3, 4000));
		for (int p = 0; p < 6; p++) begin
			write_debounce(deb_plan[p]);
			@(negedge clk);
			load_random(60);
			if (p == 2) begin
				@(posedge clk);
				hold_go <= 1'b1;
				@(posedge clk);
				hold_go <= 1'b0;
			end
			wait_drained();
		end

		// Last part, no idling: zero debounce, every edge accepted, ring refills
		idle_on <= 1'b0;
		write_debounce(12'd0);
		@(negedge clk);
		need = 28;
		k    = 0;
		while (need > 0) begin
			if (k % 8 == 7) begin
				add_item(dhef_pkg::MODE_POP, $urandom(), $urandom());
			end else begin
				add_item(dhef_pkg::MODE_EDGE, $urandom(), $urandom());
				need--;
			end
			k++;
		end
		wait_drained();
		repeat (10) @(posedge clk);

		$display("tb: %0d results checked over %0d debounce settings: %0d debounced,",
			n_checked, n_settings, status_seen[dhef_pkg::ST_DEBOUNCED]);
		$display("tb: %0d queued, %0d dropped full, %0d empty pops, %0d popped, %0d mismatches",
			status_seen[dhef_pkg::ST_QUEUED], status_seen[dhef_pkg::ST_DROPPED_FULL],
			status_seen[dhef_pkg::ST_POP_EMPTY], status_seen[dhef_pkg::ST_POP_EVENT],
			n_mismatch);
		if (n_mismatch == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#200_000;
		$display("tb: FAIL");
		$finish;
	end

endmodule
